>>> src/bnc_pkg.sv
// Package for the bracket nesting checker: stack sizing, bracket kinds,
// cell shift operations and the character decoder. No dependencies.
`timescale 1ns / 1ps

package bnc_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_BRACE  = 2'd2,
      KIND_PAREN  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD = 2'd0,
      SHIFT_PUSH = 2'd1,
      SHIFT_POP  = 2'd2
   } shift_type;

   localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
   localparam logic [7:0] CHAR_OPEN_BRACE   = 8'h7B;
   localparam logic [7:0] CHAR_OPEN_PAREN   = 8'h28;
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
   localparam logic [7:0] CHAR_CLOSE_BRACE  = 8'h7D;
   localparam logic [7:0] CHAR_CLOSE_PAREN  = 8'h29;

   typedef struct packed {
      kind_type open_kind;
      kind_type close_kind;
   } decode_type;

   function automatic decode_type decode_char(input logic [7:0] ch);
      decode_type d;
      d.open_kind  = KIND_NONE;
      d.close_kind = KIND_NONE;
      case (ch)
         CHAR_OPEN_SQUARE:  d.open_kind  = KIND_SQUARE;
         CHAR_OPEN_BRACE:   d.open_kind  = KIND_BRACE;
         CHAR_OPEN_PAREN:   d.open_kind  = KIND_PAREN;
         CHAR_CLOSE_SQUARE: d.close_kind = KIND_SQUARE;
         CHAR_CLOSE_BRACE:  d.close_kind = KIND_BRACE;
         CHAR_CLOSE_PAREN:  d.close_kind = KIND_PAREN;
         default: begin
            d.open_kind  = KIND_NONE;
            d.close_kind = KIND_NONE;
         end
      endcase
      return d;
   endfunction

endpackage

>>> src/bnc_cell.sv
// One entry of the shift stack: holds a bracket kind and takes its neighbor's
// kind on push or pop. Depends on bnc_pkg.
`timescale 1ns / 1ps

module bnc_cell
   import bnc_pkg::*;
(
   input  logic      clock,
   input  shift_type shift_op,
   input  kind_type  kind_above,
   input  kind_type  kind_below,
   output kind_type  kind
);

   kind_type kind_ff;
   kind_type kind_in;

   always_comb begin
      case (shift_op)
         SHIFT_PUSH: kind_in = kind_above;
         SHIFT_POP:  kind_in = kind_below;
         default:    kind_in = kind_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign kind = kind_ff;

endmodule

>>> src/bracket_nesting_checker_top.sv
// Bracket nesting checker: a row of bnc_cell stack entries with the push, pop
// and failure control and the result register. Depends on bnc_pkg and bnc_cell.
//
// Usage: one character per req_ beat (req_ch, req_last). On a beat with
// req_last high the character is handled and one rsp_ beat follows with
// rsp_balanced (no failure and all brackets closed) and rsp_overflowed
// (an opener found the stack full). Beats with req_last low give no result.
// The result is valid the cycle after the last character is taken.
// Throughput: one character per cycle while req_ready is high; the stack is a shift chain of
// STACK_DEPTH cells whose push or pop is decided combinationally from the top entry.
// Reset: the stack is emptied, the failure and overflow flags and the result
// valid flag clear; cell contents and the result fields are left as they are.
// Stall: while a result waits and rsp_ready is low, req_ready drops; it stays
// high while the waiting result is taken in the same cycle.
`timescale 1ns / 1ps

module bracket_nesting_checker_top
   import bnc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_balanced,
   output logic       rsp_overflowed
);

   count_type count_ff, count_in;
   logic      failed_ff, failed_in;
   logic      ovf_ff, ovf_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      balanced_ff, balanced_in;
   logic      overflowed_ff, overflowed_in;

   kind_type   kinds [STACK_DEPTH];
   shift_type  shift_op;
   kind_type   top_kind;
   kind_type   nest_level;
   decode_type dec;
   logic       accept;
   logic       fail_now, ovf_now;
   count_type  count_next;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   assign dec        = decode_char(req_ch);
   assign top_kind   = kinds[0];
   assign nest_level = (count_ff != '0) ? top_kind : KIND_NONE;

   always_comb begin
      shift_op   = SHIFT_HOLD;
      fail_now   = 1'b0;
      ovf_now    = 1'b0;
      count_next = count_ff;
      if (!failed_ff) begin
         if (dec.open_kind != KIND_NONE) begin
            if (nest_level > dec.open_kind) begin
               fail_now = 1'b1;
            end else if (count_ff == count_type'(STACK_DEPTH)) begin
               fail_now = 1'b1;
               ovf_now  = 1'b1;
            end else begin
               shift_op   = SHIFT_PUSH;
               count_next = count_ff + count_type'(1);
            end
         end else if (dec.close_kind != KIND_NONE && count_ff != '0 &&
                      top_kind == dec.close_kind) begin
            shift_op   = SHIFT_POP;
            count_next = count_ff - count_type'(1);
         end
      end
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      kind_type above, below;
      if (i == 0) begin : g_top
         assign above = dec.open_kind;
      end else begin : g_mid
         assign above = kinds[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below = KIND_NONE;
      end else begin : g_upper
         assign below = kinds[i+1];
      end
      bnc_cell u_cell (
         .clock      (clock),
         .shift_op   (accept ? shift_op : SHIFT_HOLD),
         .kind_above (above),
         .kind_below (below),
         .kind       (kinds[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      failed_in     = failed_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      balanced_in   = balanced_ff;
      overflowed_in = overflowed_ff;
      if (accept) begin
         if (req_last) begin
            rsp_valid_in  = 1'b1;
            balanced_in   = !(failed_ff || fail_now) && count_next == '0;
            overflowed_in = ovf_ff || ovf_now;
            count_in      = '0;
            failed_in     = 1'b0;
            ovf_in        = 1'b0;
         end else begin
            count_in  = count_next;
            failed_in = failed_ff || fail_now;
            ovf_in    = ovf_ff || ovf_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         failed_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         failed_ff    <= failed_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      balanced_ff   <= balanced_in;
      overflowed_ff <= overflowed_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_balanced   = balanced_ff;
   assign rsp_overflowed = overflowed_ff;

endmodule

>>> src/bnc_checker.sv
// Port-level checks for bracket_nesting_checker_top and the bind that
// attaches them. Depends on bracket_nesting_checker_top.
`timescale 1ns / 1ps

module bnc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_balanced,
   input logic       rsp_overflowed
);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_balanced) && $stable(rsp_overflowed))
      else $error("result beat changed while stalled");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_last |=> rsp_valid)
      else $error("no result after last character");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_last && (!rsp_valid || rsp_ready) |=> !rsp_valid)
      else $error("result without last character");

   a_overflow_unbalanced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |-> !rsp_balanced)
      else $error("overflowed expression reported balanced");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no result pending");

endmodule

bind bracket_nesting_checker_top bnc_checker u_bnc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_last       (req_last),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_balanced   (rsp_balanced),
   .rsp_overflowed (rsp_overflowed)
);

>>> sim/bracket_nesting_checker_top_test.sv
// Self-checking testbench for bracket_nesting_checker_top: directed and random
// expressions, a bracket stack predictor and a result scoreboard.
// Depends on bnc_pkg and the bracket_nesting_checker_top RTL.
`timescale 1ns / 1ps

module bracket_nesting_checker_top_test
   import bnc_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BEATS = 1500;

   typedef struct {
      logic [7:0] ch;
      logic       last;
      bit         hold;
   } char_beat_type;

   typedef struct {
      logic balanced;
      logic overflowed;
   } verdict_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_ch = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_balanced;
   logic       rsp_overflowed;

   char_beat_type chars_pending[$];
   verdict_type   verdicts_due[$];
   bit         hold_next = 1'b0;
   bit         drained = 1'b1;
   int         phase = 0;
   int         loaded = 0;
   int         total_beats = 1;
   int         cycles = 0;
   int         errors = 0;

   kind_type   open_kinds [STACK_DEPTH];
   int         held = 0;
   kind_type   inner_kind = KIND_NONE;
   bit         fault = 1'b0;
   bit         ovf = 1'b0;

   bracket_nesting_checker_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ch         (req_ch),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_balanced   (rsp_balanced),
      .rsp_overflowed (rsp_overflowed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int sender_idle_pct(input int p);
      case (p)
         0: return 35;
         1: return 61;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct(input int p);
      case (p)
         0: return 61;
         1: return 35;
         default: return 0;
      endcase
   endfunction

   function automatic logic [7:0] opener_char(input kind_type k);
      case (k)
         KIND_SQUARE: return CHAR_OPEN_SQUARE;
         KIND_BRACE:  return CHAR_OPEN_BRACE;
         default:     return CHAR_OPEN_PAREN;
      endcase
   endfunction

   function automatic logic [7:0] closer_char(input kind_type k);
      case (k)
         KIND_SQUARE: return CHAR_CLOSE_SQUARE;
         KIND_BRACE:  return CHAR_CLOSE_BRACE;
         default:     return CHAR_CLOSE_PAREN;
      endcase
   endfunction

   function automatic logic [7:0] filler_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      case (b)
         CHAR_OPEN_SQUARE, CHAR_OPEN_BRACE, CHAR_OPEN_PAREN,
         CHAR_CLOSE_SQUARE, CHAR_CLOSE_BRACE, CHAR_CLOSE_PAREN: b = 8'h61;
         default: ;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] bracket_byte();
      case ($urandom_range(0, 5))
         0: return CHAR_OPEN_SQUARE;
         1: return CHAR_OPEN_BRACE;
         2: return CHAR_OPEN_PAREN;
         3: return CHAR_CLOSE_SQUARE;
         4: return CHAR_CLOSE_BRACE;
         default: return CHAR_CLOSE_PAREN;
      endcase
   endfunction

   task automatic add_char(input logic [7:0] ch, input logic last = 1'b0);
      char_beat_type b;
      b.ch   = ch;
      b.last = last;
      b.hold = hold_next;
      hold_next = 1'b0;
      chars_pending.push_back(b);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_char(s[i], i == s.len() - 1);
      end
   endtask

   task automatic end_expr();
      char_beat_type b;
      b = chars_pending.pop_back();
      b.last = 1'b1;
      chars_pending.push_back(b);
   endtask

   // well-formed expression: openers never go shallower in order than the top
   task automatic add_nested_expr(input int opens, input int noise_pct);
      kind_type shape[$];
      kind_type top;
      kind_type k;
      int       opened;
      int       r;
      opened = 0;
      while (opened < opens || shape.size() != 0) begin
         top = (shape.size() != 0) ? shape[$] : KIND_NONE;
         r = $urandom_range(0, 99);
         if (r < noise_pct) begin
            add_char(filler_byte());
         end else if (opened < opens && (shape.size() == 0 || r < 55 + noise_pct / 2)) begin
            k = kind_type'($urandom_range((top == KIND_NONE) ? 1 : int'(top), 3));
            add_char(opener_char(k));
            shape.push_back(k);
            opened++;
         end else begin
            add_char(closer_char(top));
            void'(shape.pop_back());
         end
      end
      end_expr();
   endtask

   task automatic take_char(input logic [7:0] ch, input logic last);
      kind_type opener;
      kind_type closer;
      verdict_type v;
      opener = KIND_NONE;
      closer = KIND_NONE;
      case (ch)
         CHAR_OPEN_SQUARE:  opener = KIND_SQUARE;
         CHAR_OPEN_BRACE:   opener = KIND_BRACE;
         CHAR_OPEN_PAREN:   opener = KIND_PAREN;
         CHAR_CLOSE_SQUARE: closer = KIND_SQUARE;
         CHAR_CLOSE_BRACE:  closer = KIND_BRACE;
         CHAR_CLOSE_PAREN:  closer = KIND_PAREN;
         default: ;
      endcase
      if (!fault) begin
         if (opener != KIND_NONE) begin
            if (inner_kind > opener) begin
               fault = 1'b1;
            end else if (held >= STACK_DEPTH) begin
               fault = 1'b1;
               ovf   = 1'b1;
            end else begin
               open_kinds[held] = opener;
               held++;
               inner_kind = opener;
            end
         end else if (closer != KIND_NONE && held > 0 && open_kinds[held-1] == closer) begin
            held--;
            inner_kind = (held > 0) ? open_kinds[held-1] : KIND_NONE;
         end
      end
      if (last) begin
         v.balanced   = !fault && held == 0;
         v.overflowed = ovf;
         verdicts_due.push_back(v);
         held       = 0;
         inner_kind = KIND_NONE;
         fault      = 1'b0;
         ovf        = 1'b0;
      end
   endtask

   task automatic report(input string msg);
      if (errors < 10) begin
         $display("%0t: %s", $realtime, msg);
      end
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_ch    <= 8'h00;
         req_last  <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (chars_pending.size() != 0 &&
             !(chars_pending[0].hold && (req_valid || !drained)) &&
             $urandom_range(0, 99) >= sender_idle_pct(phase)) begin
            req_valid <= 1'b1;
            req_ch    <= chars_pending[0].ch;
            req_last  <= chars_pending[0].last;
            void'(chars_pending.pop_front());
            loaded++;
            phase <= loaded * 3 / total_beats;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         drained   <= 1'b1;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               report($sformatf("unexpected result balanced=%0b overflowed=%0b",
                                rsp_balanced, rsp_overflowed));
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_balanced !== want.balanced || rsp_overflowed !== want.overflowed) begin
                  report($sformatf("balanced exp %0b got %0b, overflowed exp %0b got %0b",
                                   want.balanced, rsp_balanced,
                                   want.overflowed, rsp_overflowed));
               end
            end
         end
         if (req_valid && req_ready) begin
            take_char(req_ch, req_last);
         end
         drained   <= verdicts_due.size() == 0;
         rsp_ready <= $urandom_range(0, 99) >= receiver_idle_pct(phase);
      end
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** bracket_nesting_checker_top: FAILED **");
         $finish;
      end
   end

   initial begin
      int mode;
      int exprs;
      int depth;
      int len;

      // extremes of the byte, nesting order, mismatches, failure, overflow
      add_char(8'h00, 1'b1);
      add_char(8'hFF, 1'b1);
      add_text("[{()}]");
      add_text("([])");
      add_text("{[]}");
      add_text("(]");
      add_text("]");
      add_text("([)");
      repeat (STACK_DEPTH + 1) add_char(CHAR_OPEN_PAREN);
      add_char(CHAR_CLOSE_PAREN, 1'b1);

      exprs = 0;
      while (chars_pending.size() < RANDOM_BEATS) begin
         if (exprs % 40 == 20) begin
            hold_next = 1'b1;
         end
         mode = $urandom_range(0, 99);
         if (mode < 60) begin
            add_nested_expr($urandom_range(1, 8), (mode < 40) ? 0 : 25);
         end else if (mode < 80) begin
            len = $urandom_range(1, 10);
            repeat (len) begin
               add_char(($urandom_range(0, 99) < 75) ? bracket_byte() : 8'($urandom_range(0, 255)));
            end
            end_expr();
         end else if (mode < 97) begin
            len = $urandom_range(1, 8);
            repeat (len) add_char(8'($urandom_range(0, 255)));
            end_expr();
         end else begin
            depth = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
            add_nested_expr(depth, 0);
         end
         exprs++;
      end
      total_beats = chars_pending.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (chars_pending.size() == 0);
      @(posedge clock);
      while (req_valid || verdicts_due.size() != 0 || !drained) @(posedge clock);
      repeat (8) @(posedge clock);

      if (errors == 0) begin
         $display("** bracket_nesting_checker_top: PASSED **");
      end else begin
         $display("** bracket_nesting_checker_top: FAILED **");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/bnc_pkg.sv
src/bnc_cell.sv
src/bracket_nesting_checker_top.sv
src/bnc_checker.sv
sim/bracket_nesting_checker_top_test.sv
